FILE: rtl/core/hwtd_pkg.sv
`default_nettype none
package hwtd_pkg;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DECODE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_SYM = 2'd0;
	localparam logic [1:0] KIND_ACK = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_FULL   = 2'd1;
	localparam logic [1:0] ERR_BRANCH = 2'd2;
	localparam logic [1:0] ERR_LEN    = 2'd3;

	localparam int CODE_W = 32;

	typedef struct packed {
		logic [1:0]        command;
		logic [7:0]        symbol_in;
		logic [CODE_W-1:0] code_bits;
		logic [5:0]        code_length;
		logic [7:0]        data_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol_out;
		logic [1:0] error_code;
		logic       last;
	} result_t;

	// result events from the walk sequencer to the output stage
	typedef struct packed {
		logic    new_v;
		logic    fin;
		result_t res;
	} gen_t;

endpackage
`default_nettype wire

FILE: rtl/core/hwtd_ram.sv
`default_nettype none
module hwtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/hwtd_out_stage.sv
`default_nettype none
module hwtd_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hwtd_pkg::gen_t   gen,
	output logic                  strobe,
	output hwtd_pkg::result_t     result
);
	import hwtd_pkg::*;

	// one result is held back so the final one can carry last
	result_t pend_q;
	logic    pend_v_q;
	logic    strobe_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (gen.new_v || gen.fin) begin
				strobe_q <= pend_v_q;
			end else begin
				strobe_q <= 1'b0;
			end
			if (gen.new_v) begin
				pend_v_q <= 1'b1;
			end else if (gen.fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen.new_v) begin
			pend_q <= gen.res;
			result_q <= '{kind: pend_q.kind, symbol_out: pend_q.symbol_out,
				error_code: pend_q.error_code, last: 1'b0};
		end else if (gen.fin) begin
			result_q <= '{kind: pend_q.kind, symbol_out: pend_q.symbol_out,
				error_code: pend_q.error_code, last: 1'b1};
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;
endmodule
`default_nettype wire

FILE: rtl/core/huffman_tree_walk_decoder_unit.sv
`default_nettype none
// huffman tree-walk decoder: the code tree lives in a node memory and is
// walked one bit per cycle while it follows existing nodes; node creation
// and a decoded symbol's leaf check take steps of their own. pulse start
// while busy is low to transfer one command on item. insert walks its code
// from the root, hooks each missing node into its parent and then allocates
// it, then stores the symbol and finishes. decode walks the byte from the
// saved position, whose node is fetched in the transfer cycle itself: a step
// per bit, a leaf check per decoded symbol, a step to see the bits end and a
// finish step, or an error at a missing branch. the walk is paced by the node
// memory's registered read, since each step needs the node fetched by the
// step before. clear and length errors go straight to finish, and busy drops
// between commands. results come out on result with a one-cycle strobe and
// cannot be held off by the receiver; the final result of a command carries
// last. one result is held back internally, so each is handed out when the
// next one or the finish arrives, and busy stays high until the last one
// reaches the output register. pad_bits is to be written through cfg_we and
// cfg_wdata while the block is idle, which the block does not enforce. the
// node memory needs no clearing: only allocated nodes are ever linked
module huffman_tree_walk_decoder_unit #(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire hwtd_pkg::in_item_t item,
	output logic                    strobe,
	output hwtd_pkg::result_t       result,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_wdata
);
	import hwtd_pkg::*;

	// link width, free counter width, node entry width {link1, link0, symbol}
	localparam int LW = $clog2(NODE_COUNT);
	localparam int FW = $clog2(NODE_COUNT + 1);
	localparam int EW = 2 * LW + 8;
	localparam int LEN_MAX = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [6:0] LEN_LIMIT = 7'(LEN_MAX);
	localparam logic [FW-1:0] NODE_LIMIT = FW'(NODE_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_INS,
		ST_ALLOC,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;

	// walk state
	logic [LW-1:0]     pos_q, pos_d;          // current node, 0 is the root
	logic [LW-1:0]     walk_pos_q, walk_pos_d; // decode position kept between bytes
	logic [LW-1:0]     root0_q, root0_d, root1_q, root1_d;
	logic [FW-1:0]     free_q, free_d;
	logic [5:0]        cnt_q, cnt_d;          // bits left to walk
	logic              fresh_q, fresh_d;      // current node was just created
	logic [1:0]        cmd_q, cmd_d;
	logic              eos_q, eos_d;
	logic [2:0]        pad_q;

	// payload
	logic [CODE_W-1:0] bits_q, bits_d;        // next bit to walk sits at the top
	logic [7:0]        sym_q, sym_d;

	// node memory
	logic          ram_we, ram_re;
	logic [LW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	hwtd_ram #(
		.WIDTH(EW),
		.DEPTH(NODE_COUNT)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// current node entry: a new node reads as empty without a fetch
	logic [EW-1:0] cur;
	logic [LW-1:0] cur_l0, cur_l1, link0, link1, nxt;
	logic [7:0]    cur_sym;
	logic          leaf;
	logic [LW-1:0] free_idx;
	logic [5:0]    len_shift;
	logic [2:0]    stop;
	gen_t          gen;

	assign cur      = fresh_q ? '0 : ram_rdata;
	assign cur_l1   = cur[EW-1 -: LW];
	assign cur_l0   = cur[LW+7 -: LW];
	assign cur_sym  = cur[7:0];
	assign link0    = (pos_q == '0) ? root0_q : cur_l0;
	assign link1    = (pos_q == '0) ? root1_q : cur_l1;
	assign nxt      = bits_q[CODE_W-1] ? link1 : link0;
	assign leaf     = (pos_q != '0) && (cur_l0 == '0) && (cur_l1 == '0);
	assign free_idx = free_q[LW-1:0];
	assign len_shift = 6'd32 - item.code_length;
	assign stop     = item.end_of_stream ? pad_q : 3'd0;

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		walk_pos_d = walk_pos_q;
		root0_d    = root0_q;
		root1_d    = root1_q;
		free_d     = free_q;
		cnt_d      = cnt_q;
		fresh_d    = fresh_q;
		cmd_d      = cmd_q;
		eos_d      = eos_q;
		bits_d     = bits_q;
		sym_d      = sym_q;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = cur;
		ram_re     = 1'b0;
		ram_raddr  = nxt;
		gen        = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_d = item.command;
					eos_d = item.end_of_stream;
					sym_d = item.symbol_in;
					case (item.command)
						CMD_INSERT: begin
							if (item.code_length == 6'd0 ||
									{1'b0, item.code_length} > LEN_LIMIT) begin
								gen.new_v          = 1'b1;
								gen.res.kind       = KIND_ERR;
								gen.res.error_code = ERR_LEN;
								state_d            = ST_FINISH;
							end else begin
								bits_d  = item.code_bits << len_shift;
								cnt_d   = item.code_length;
								pos_d   = '0;
								fresh_d = 1'b0;
								state_d = ST_INS;
							end
						end
						CMD_DECODE: begin
							bits_d    = {item.data_byte, {(CODE_W-8){1'b0}}};
							cnt_d     = 6'd8 - {3'b000, stop};
							pos_d     = walk_pos_q;
							fresh_d   = 1'b0;
							ram_re    = 1'b1;
							ram_raddr = walk_pos_q;
							state_d   = ST_WALK;
						end
						CMD_CLEAR: begin
							root0_d      = '0;
							root1_d      = '0;
							free_d       = FW'(1);
							walk_pos_d   = '0;
							gen.new_v    = 1'b1;
							gen.res.kind = KIND_ACK;
							state_d      = ST_FINISH;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (leaf) begin
					gen.new_v          = 1'b1;
					gen.res.kind       = KIND_SYM;
					gen.res.symbol_out = cur_sym;
					pos_d              = '0;
				end else if (cnt_q != 6'd0) begin
					if (nxt == '0) begin
						gen.new_v          = 1'b1;
						gen.res.kind       = KIND_ERR;
						gen.res.error_code = ERR_BRANCH;
						pos_d              = '0;
						state_d            = ST_FINISH;
					end else begin
						ram_re = 1'b1;
						pos_d  = nxt;
						bits_d = bits_q << 1;
						cnt_d  = cnt_q - 6'd1;
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_INS: begin
				if (cnt_q == 6'd0) begin
					// end of code: place the symbol on the node reached
					ram_we       = 1'b1;
					ram_wdata    = {cur_l1, cur_l0, sym_q};
					gen.new_v    = 1'b1;
					gen.res.kind = KIND_ACK;
					state_d      = ST_FINISH;
				end else if (nxt != '0) begin
					ram_re  = 1'b1;
					pos_d   = nxt;
					fresh_d = 1'b0;
					bits_d  = bits_q << 1;
					cnt_d   = cnt_q - 6'd1;
				end else if (free_q >= NODE_LIMIT) begin
					gen.new_v          = 1'b1;
					gen.res.kind       = KIND_ERR;
					gen.res.error_code = ERR_FULL;
					state_d            = ST_FINISH;
				end else begin
					// hook the new node into its parent, create it next cycle
					if (pos_q == '0) begin
						if (bits_q[CODE_W-1]) begin
							root1_d = free_idx;
						end else begin
							root0_d = free_idx;
						end
					end else begin
						ram_we    = 1'b1;
						ram_wdata = bits_q[CODE_W-1] ? {free_idx, cur_l0, cur_sym}
							: {cur_l1, free_idx, cur_sym};
					end
					state_d = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				ram_we    = 1'b1;
				ram_waddr = free_idx;
				ram_wdata = '0;
				pos_d     = free_idx;
				free_d    = free_q + FW'(1);
				fresh_d   = 1'b1;
				bits_d    = bits_q << 1;
				cnt_d     = cnt_q - 6'd1;
				state_d   = ST_INS;
			end
			ST_FINISH: begin
				gen.fin = 1'b1;
				if (cmd_q == CMD_DECODE) begin
					walk_pos_d = eos_q ? '0 : pos_q;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			walk_pos_q <= '0;
			root0_q    <= '0;
			root1_q    <= '0;
			free_q     <= FW'(1);
			cnt_q      <= '0;
			fresh_q    <= 1'b0;
			cmd_q      <= CMD_INSERT;
			eos_q      <= 1'b0;
			pad_q      <= '0;
		end else begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			walk_pos_q <= walk_pos_d;
			root0_q    <= root0_d;
			root1_q    <= root1_d;
			free_q     <= free_d;
			cnt_q      <= cnt_d;
			fresh_q    <= fresh_d;
			cmd_q      <= cmd_d;
			eos_q      <= eos_d;
			if (cfg_we) begin
				pad_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		bits_q <= bits_d;
		sym_q  <= sym_d;
	end

	assign busy = (state_q != ST_IDLE);

	hwtd_out_stage u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.gen   (gen),
		.strobe(strobe),
		.result(result)
	);

	// the free pointer never runs past the store and never hits the root
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q != '0 && free_q <= NODE_LIMIT)
		else $error("node free pointer out of range");

	// clear empties the tree and returns the walk to the root
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command == CMD_CLEAR |=>
		root0_q == '0 && root1_q == '0 && walk_pos_q == '0 && free_q == FW'(1))
		else $error("clear left tree state behind");

	// an error always ends the command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_ERR |-> result.last)
		else $error("error result not final");

	// the final result of a command is never directly followed by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("result follows final result too closely");

endmodule
`default_nettype wire
